// File: rtl/gcbs_pkg.sv
// Shared types and constants for the graph colouring backtracking search.
// No dependencies; every other file in rtl/ refers to it by scoped name.
package gcbs_pkg;

  localparam int unsigned NumVerticesDef = 8;
  localparam int unsigned MaxColorsDef   = 8;

  localparam int unsigned RowIdxW   = 3;
  localparam int unsigned RowBitsW  = 8;
  localparam int unsigned ColorW    = 4;
  localparam logic [ColorW-1:0] NumColorsRst = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_row;
    logic start;
    logic step;
    logic emit_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_ok;
    logic srch_fail;
    logic emit_last;
  } sts_t;

endpackage

// File: rtl/gcbs_if.sv
// Valid/ready channel interfaces for adjacency rows in and colour words out.
// Depends on gcbs_pkg for the field widths.
interface gcbs_row_if;
  logic                              valid;
  logic                              ready;
  logic [gcbs_pkg::RowIdxW-1:0]      row_index;
  logic [gcbs_pkg::RowBitsW-1:0]     row_bits;
  logic                              last_row;

  modport source (output valid, row_index, row_bits, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

interface gcbs_res_if;
  logic                              valid;
  logic                              ready;
  logic [gcbs_pkg::RowIdxW-1:0]      vertex_index;
  logic [gcbs_pkg::ColorW-1:0]       vertex_color;
  logic                              found;
  logic                              last_of_run;

  modport source (output valid, vertex_index, vertex_color, found, last_of_run, input ready);
  modport sink   (input valid, vertex_index, vertex_color, found, last_of_run, output ready);
endinterface

// File: rtl/gcbs_ctrl.sv
// Sequencer for row loading, the backtracking search and result emission.
// Depends on gcbs_pkg for the state enum and the command/status structs.
module gcbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  gcbs_pkg::sts_t   sts_i,
  output gcbs_pkg::cmd_t   cmd_o
);

  gcbs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gcbs_pkg::ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = gcbs_pkg::ST_SEARCH;
      end
      gcbs_pkg::ST_SEARCH: begin
        if (sts_i.srch_ok || sts_i.srch_fail) state_d = gcbs_pkg::ST_EMIT;
      end
      gcbs_pkg::ST_EMIT: begin
        if (out_ready_i && sts_i.emit_last) state_d = gcbs_pkg::ST_IDLE;
      end
      default: state_d = gcbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o          = '0;
    case (state_q)
      gcbs_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_row = in_valid_i;
        cmd_o.start    = in_valid_i && in_last_i;
      end
      gcbs_pkg::ST_SEARCH: begin
        cmd_o.step = 1'b1;
      end
      gcbs_pkg::ST_EMIT: begin
        out_valid_o    = 1'b1;
        cmd_o.emit_adv = out_ready_i && !sts_i.emit_last;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/gcbs_dp.sv
// Datapath: adjacency rows, colour registers, depth and candidate counters.
// One candidate colour is tested against all vertices per step.
// Depends on gcbs_pkg for widths and the command/status structs.
module gcbs_dp #(
  parameter int unsigned NUM_VERTICES = gcbs_pkg::NumVerticesDef,
  parameter int unsigned MAX_COLORS   = gcbs_pkg::MaxColorsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gcbs_pkg::cmd_t                    cmd_i,
  output gcbs_pkg::sts_t                    sts_o,
  input  logic [gcbs_pkg::ColorW-1:0]       num_colors_i,
  input  logic [gcbs_pkg::RowIdxW-1:0]      row_index_i,
  input  logic [gcbs_pkg::RowBitsW-1:0]     row_bits_i,
  output logic [gcbs_pkg::RowIdxW-1:0]      vertex_index_o,
  output logic [gcbs_pkg::ColorW-1:0]       vertex_color_o,
  output logic                              found_o
);

  localparam int unsigned IdxW   = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned DepthW = $clog2(NUM_VERTICES + 1);
  localparam int unsigned CandW  = $clog2(MAX_COLORS + 2);
  localparam int unsigned ColorW = gcbs_pkg::ColorW;

  logic [gcbs_pkg::RowBitsW-1:0] adj_q    [NUM_VERTICES];
  logic [ColorW-1:0]             colors_q [NUM_VERTICES];
  logic [DepthW-1:0]             depth_q;
  logic [CandW-1:0]              cand_q;
  logic [IdxW-1:0]               emit_q;
  logic                          found_q;

  logic [IdxW-1:0]   d_idx, prev_idx, rd_idx;
  logic [CandW-1:0]  ncol;
  logic [ColorW-1:0] rd_color;
  logic              at_end, cand_ok, conflict, at_root;

  assign d_idx    = depth_q[IdxW-1:0];
  assign prev_idx = IdxW'(depth_q - DepthW'(1));
  assign at_end   = (depth_q == DepthW'(NUM_VERTICES));
  assign at_root  = (depth_q == '0);

  // clamp the colour count to what the candidate counter covers
  assign ncol    = (num_colors_i > ColorW'(MAX_COLORS)) ? CandW'(MAX_COLORS)
                                                          : CandW'(num_colors_i);
  assign cand_ok = (cand_q <= ncol);

  always_comb begin
    conflict = 1'b0;
    for (int unsigned i = 0; i < NUM_VERTICES; i++) begin
      if (adj_q[i][d_idx]) begin
        if (IdxW'(i) == d_idx) conflict = 1'b1;
        else if (CandW'(colors_q[i]) == cand_q) conflict = 1'b1;
      end
    end
  end

  // single read port: previous vertex while searching, emit pointer otherwise
  assign rd_idx   = cmd_i.step ? prev_idx : emit_q;
  assign rd_color = colors_q[rd_idx];

  assign sts_o.srch_ok   = cmd_i.step && at_end;
  assign sts_o.srch_fail = cmd_i.step && !at_end && !cand_ok && at_root;
  assign sts_o.emit_last = !found_q || (emit_q == IdxW'(NUM_VERTICES - 1));

  assign vertex_index_o = gcbs_pkg::RowIdxW'(emit_q);
  assign vertex_color_o = found_q ? rd_color : '0;
  assign found_o        = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_VERTICES; i++) begin
        adj_q[i]    <= '0;
        colors_q[i] <= '0;
      end
      depth_q <= '0;
      cand_q  <= CandW'(1);
      emit_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.load_row && ({1'b0, row_index_i} < 4'(NUM_VERTICES))) begin
        adj_q[IdxW'(row_index_i)] <= row_bits_i;
      end
      if (cmd_i.start) begin
        for (int unsigned i = 0; i < NUM_VERTICES; i++) colors_q[i] <= '0;
        depth_q <= '0;
        cand_q  <= CandW'(1);
        emit_q  <= '0;
      end
      if (cmd_i.step) begin
        if (at_end) begin
          found_q <= 1'b1;
        end else if (!cand_ok) begin
          // out of colours here: uncolour, then back up unless at the root
          colors_q[d_idx] <= '0;
          if (at_root) begin
            found_q <= 1'b0;
          end else begin
            depth_q <= depth_q - DepthW'(1);
            cand_q  <= CandW'(rd_color) + CandW'(1);
          end
        end else if (conflict) begin
          cand_q <= cand_q + CandW'(1);
        end else begin
          colors_q[d_idx] <= ColorW'(cand_q);
          depth_q         <= depth_q + DepthW'(1);
          cand_q          <= CandW'(1);
        end
      end
      if (cmd_i.emit_adv) emit_q <= emit_q + IdxW'(1);
    end
  end

endmodule

// File: rtl/graph_coloring_backtrack_search.sv
// Graph colouring search: row words are taken while idle; the last row starts the search.
// Search: one candidate colour tested per cycle; each backtrack and the final check
// use a search step of their own.
// Results: NUM_VERTICES words (one on failure), one per cycle while the sink is ready.
// Reset clears the adjacency rows, the colours and sets num_colors to 3.
module graph_coloring_backtrack_search #(
  parameter int unsigned NUM_VERTICES = gcbs_pkg::NumVerticesDef,
  parameter int unsigned MAX_COLORS   = gcbs_pkg::MaxColorsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gcbs_row_if.sink                     in_i,
  gcbs_res_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [gcbs_pkg::ColorW-1:0]  cfg_wdata_i
);

  logic [gcbs_pkg::ColorW-1:0] num_colors_q;
  gcbs_pkg::cmd_t              cmd;
  gcbs_pkg::sts_t              sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_colors_q <= gcbs_pkg::NumColorsRst;
    end else if (cfg_we_i) begin
      num_colors_q <= cfg_wdata_i;
    end
  end

  gcbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_row),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gcbs_dp #(
    .NUM_VERTICES (NUM_VERTICES),
    .MAX_COLORS   (MAX_COLORS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .num_colors_i   (num_colors_q),
    .row_index_i    (in_i.row_index),
    .row_bits_i     (in_i.row_bits),
    .vertex_index_o (out_o.vertex_index),
    .vertex_color_o (out_o.vertex_color),
    .found_o        (out_o.found)
  );

  assign out_o.last_of_run = sts.emit_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_o.valid && in_i.ready))
    else $error("input taken while results pending");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_of_run) |=> in_i.ready)
    else $error("not idle after final word");

  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.last_of_run && out_o.vertex_color == '0))
    else $error("not-found word malformed");

  a_found_colored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> (out_o.vertex_color != '0))
    else $error("uncoloured vertex reported");
`endif

endmodule

// File: tb/sv/colouring_checker.sv
`timescale 1ns / 1ps
// Checker for the graph colouring search: follows the row and result channels and the
// colour count register, predicts each result word and compares it with the word seen.
// Depends on gcbs_pkg and on the channel interfaces of gcbs_if.sv.
module colouring_checker #(
  parameter int unsigned NUM_VERTICES = gcbs_pkg::NumVerticesDef,
  parameter int unsigned MAX_COLORS   = gcbs_pkg::MaxColorsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gcbs_row_if                         rows_i,
  gcbs_res_if                         words_i,
  input  logic                        cfg_we_i,
  input  logic [gcbs_pkg::ColorW-1:0] cfg_wdata_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 words_due_o
);

  localparam int unsigned RowIdxW  = gcbs_pkg::RowIdxW;
  localparam int unsigned RowBitsW = gcbs_pkg::RowBitsW;
  localparam int unsigned ColorW   = gcbs_pkg::ColorW;

  typedef struct packed {
    logic [RowIdxW-1:0] vertex;
    logic [ColorW-1:0]  colour;
    logic               found;
    logic               last;
  } colour_word_t;

  typedef logic [RowBitsW-1:0] adj_rows_t [NUM_VERTICES];
  typedef logic [ColorW-1:0]   colours_t  [NUM_VERTICES];

  adj_rows_t         adj_rows;
  logic [ColorW-1:0] num_colours;
  colour_word_t      words_due [$];
  colours_t          colouring;
  colour_word_t      want;
  colour_word_t      got;
  int                colour_cap;

  // Depth first: smallest colour first, back up one vertex when nothing fits.
  // Only coloured vertices can clash; a self loop clashes with every colour.
  function automatic logic solve_colouring(input adj_rows_t rows, input int ncol,
                                           output colours_t colours);
    int   d;
    int   c;
    logic placed;
    logic clash;
    foreach (colours[i]) colours[i] = '0;
    d = 0;
    while (d >= 0 && d < int'(NUM_VERTICES)) begin
      placed = 1'b0;
      for (c = int'(colours[d]) + 1; c <= ncol && !placed; c++) begin
        clash = 1'b0;
        for (int i = 0; i < int'(NUM_VERTICES); i++) begin
          if (rows[i][d] && ((i == d) ? c : int'(colours[i])) == c) clash = 1'b1;
        end
        if (!clash) begin
          colours[d] = ColorW'(c);
          placed     = 1'b1;
        end
      end
      if (placed) begin
        d++;
      end else begin
        colours[d] = '0;
        d--;
      end
    end
    return d >= 0;
  endfunction

  function automatic string word_text(input colour_word_t w);
    return $sformatf("vertex %0d colour %0d found %0b last %0b",
                     w.vertex, w.colour, w.found, w.last);
  endfunction

  function automatic void note_failure(input string what, input colour_word_t exp_w,
                                       input colour_word_t act_w);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected %s", word_text(exp_w));
      $display("  got      %s", word_text(act_w));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      num_colours  = gcbs_pkg::NumColorsRst;
      fail_count_o = 0;
      words_due.delete();
    end else begin
      if (cfg_we_i) num_colours = cfg_wdata_i;
      if (rows_i.valid && rows_i.ready) begin
        adj_rows[rows_i.row_index] = rows_i.row_bits;
        if (rows_i.last_row) begin
          colour_cap = (num_colours > MAX_COLORS) ? MAX_COLORS : num_colours;
          if (solve_colouring(adj_rows, colour_cap, colouring)) begin
            for (int v = 0; v < int'(NUM_VERTICES); v++) begin
              want.vertex = RowIdxW'(v);
              want.colour = colouring[v];
              want.found  = 1'b1;
              want.last   = (v == int'(NUM_VERTICES) - 1);
              words_due.push_back(want);
            end
          end else begin
            want = '{vertex: '0, colour: '0, found: 1'b0, last: 1'b1};
            words_due.push_back(want);
          end
        end
      end
      if (words_i.valid && words_i.ready) begin
        got.vertex = words_i.vertex_index;
        got.colour = words_i.vertex_color;
        got.found  = words_i.found;
        got.last   = words_i.last_of_run;
        if (words_due.size() == 0) begin
          note_failure("result word with nothing due", '0, got);
        end else begin
          want = words_due.pop_front();
          if (got !== want) note_failure("result word mismatch", want, got);
        end
      end
    end
    words_due_o = words_due.size();
  end

endmodule

// File: tb/sv/graph_coloring_backtrack_search_tb.sv
`timescale 1ns / 1ps
// Top of the graph colouring search testbench: clock, reset, row stimulus, result back
// pressure and colour count writes. Depends on gcbs_pkg, gcbs_if.sv and colouring_checker.
module graph_coloring_backtrack_search_tb;

  localparam int unsigned NumVertices = gcbs_pkg::NumVerticesDef;
  localparam int unsigned MaxColors   = gcbs_pkg::MaxColorsDef;
  localparam int unsigned RowIdxW     = gcbs_pkg::RowIdxW;
  localparam int unsigned RowBitsW    = gcbs_pkg::RowBitsW;
  localparam int unsigned ColorW      = gcbs_pkg::ColorW;
  localparam int unsigned PhaseRows   = 21;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned SettleCycles = 16;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ColorW-1:0] cfg_wdata;
  int unsigned       fail_count;
  int unsigned       words_due;
  int unsigned       send_idle_pct;
  int unsigned       sink_stall_pct;
  int unsigned       rows_sent;
  int unsigned       colours_eff;
  int unsigned       phase_target;

  logic [ColorW-1:0] phase_colours [NumPhases] = '{4'd2, 4'd3, 4'd8, 4'd1,
                                                   4'd5, 4'd3, 4'd15, 4'd0};

  gcbs_row_if rows ();
  gcbs_res_if words ();

  graph_coloring_backtrack_search #(
    .NUM_VERTICES (NumVertices),
    .MAX_COLORS   (MaxColors)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (rows),
    .out_o       (words),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  colouring_checker #(
    .NUM_VERTICES (NumVertices),
    .MAX_COLORS   (MaxColors)
  ) i_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rows_i       (rows),
    .words_i      (words),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin
    words.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Drop valid through the gap cycles, then offer the word until it is taken.
  task automatic send_row(input logic [RowIdxW-1:0] idx, input logic [RowBitsW-1:0] bits,
                          input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      rows.valid <= 1'b0;
      @(negedge clk);
    end
    rows.valid     <= 1'b1;
    rows.row_index <= idx;
    rows.row_bits  <= bits;
    rows.last_row  <= last;
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
    @(negedge clk);
    rows_sent++;
  endtask

  task automatic drain();
    rows.valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_colours(input logic [ColorW-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we    <= 1'b0;
    colours_eff = (n > MaxColors) ? MaxColors : n;
  endtask

  function automatic logic [RowBitsW-1:0] random_row(input int unsigned v);
    logic [RowBitsW-1:0] bits;
    int unsigned         keep;
    case ($urandom_range(2))
      0: bits = RowBitsW'($urandom);
      1: bits = RowBitsW'($urandom & $urandom);
      default: bits = RowBitsW'($urandom | $urandom);
    endcase
    bits[v] = ($urandom_range(7) == 0);
    // With four colours or more, limit each vertex to fewer earlier neighbours than
    // colours and self loops to the first two vertices, so the search never backs up far.
    if (colours_eff >= 4) begin
      keep = ((1 << v) - 1) | (((1 << (colours_eff - 1)) - 1) << (v + 1));
      if (v < 2) keep |= 1 << v;
      bits &= RowBitsW'(keep);
    end
    return bits;
  endfunction

  task automatic random_run(input bit whole);
    logic [RowIdxW-1:0] order [NumVertices];
    logic [RowIdxW-1:0] tmp;
    int unsigned        count;
    int unsigned        j;
    foreach (order[i]) order[i] = RowIdxW'(i);
    for (int i = NumVertices - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    count = whole ? NumVertices : $urandom_range(3, 1);
    for (int k = 0; k < int'(count); k++) begin
      send_row(order[k], random_row(order[k]), k == int'(count) - 1);
    end
  endtask

  initial begin
    rows.valid     = 1'b0;
    rows.row_index = '0;
    rows.row_bits  = '0;
    rows.last_row  = 1'b0;
    words.ready    = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    rows_sent      = 0;
    colours_eff    = gcbs_pkg::NumColorsRst;
    rst_n          = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty graph at the reset colour count: every vertex takes colour 1
    send_row(3'd0, 8'h00, 1'b1);
    // triangle on the first three vertices
    send_row(3'd0, 8'h06, 1'b0);
    send_row(3'd1, 8'h04, 1'b0);
    send_row(3'd2, 8'h00, 1'b1);
    // self loop on the top vertex, all bits set
    send_row(3'd7, 8'hFF, 1'b1);
    // four-clique against three colours
    send_row(3'd7, 8'h00, 1'b0);
    send_row(3'd0, 8'h0E, 1'b0);
    send_row(3'd1, 8'h0C, 1'b0);
    send_row(3'd2, 8'h08, 1'b0);
    send_row(3'd3, 8'h00, 1'b1);
    set_colours(4'd1);
    send_row(3'd4, 8'h00, 1'b1);
    // no colour allowed at all
    set_colours(4'd0);
    send_row(3'd5, 8'h00, 1'b1);
    // count above the maximum is clipped
    set_colours(4'd15);
    send_row(3'd0, 8'hFE, 1'b1);
    // complete graph: fits in eight colours, not in seven
    set_colours(4'd8);
    for (int i = 0; i < int'(NumVertices); i++) begin
      send_row(RowIdxW'(i), RowBitsW'(8'hFF << (i + 1)), i == int'(NumVertices) - 1);
    end
    set_colours(4'd7);
    send_row(3'd0, 8'hFE, 1'b1);

    for (int p = 0; p < int'(NumPhases); p++) begin
      set_colours(phase_colours[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin send_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      phase_target = rows_sent + PhaseRows;
      // rewrite every row first so leftovers from the last phase cannot slow the search
      random_run(1'b1);
      if (p == 1) drain();
      while (rows_sent < phase_target) begin
        random_run($urandom_range(9) < 7);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
